>>> rtl/parameter_list_decoder_top_defines.svh
// Assertion macros for the parameter list decoder.
// Included by files that check their own logic; no other dependencies.
`ifndef PARAMETER_LIST_DECODER_TOP_DEFINES_SVH
`define PARAMETER_LIST_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`define PLD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLD_ASSERT(lbl, prop, msg)
`define PLD_ASSERT_IMPL(lbl, ante, cons, msg)
`define PLD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/pld_pkg.sv
// Shared types and constants for the parameter list decoder.
// No dependencies.
package pld_pkg;

  localparam int unsigned LengthBitsDef = 16;
  localparam int unsigned HdrBytes      = 4;
  localparam int unsigned FifoDepth     = 4;
  localparam int unsigned FifoPtrW      = $clog2(FifoDepth);
  localparam int unsigned FifoCntW      = $clog2(FifoDepth + 1);
  localparam int unsigned CfgIdxW       = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIST_SCHEME = 2'd0,
    CFG_SENTINEL_ID = 2'd1,
    CFG_PAD_ID      = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ENCAP = 3'd1,
    PH_HDR   = 3'd2,
    PH_VALUE = 3'd3,
    PH_SKIP  = 3'd4,
    PH_DONE  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    K_VALUE  = 3'd0,
    K_EMPTY  = 3'd1,
    K_SENT   = 3'd2,
    K_DEND   = 3'd3,
    K_BADHDR = 3'd4,
    K_OVER   = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] param_id;
    logic [15:0] param_length;
    logic [15:0] byte_index;
    logic [7:0]  value_byte;
    logic        last_in_param;
  } res_t;

  typedef struct packed {
    logic [15:0] list_scheme;
    logic [15:0] sentinel_id;
    logic [15:0] pad_id;
  } cfg_t;

  // up to two results per byte: res0 first
  typedef struct packed {
    logic [1:0] n;
    res_t       res0;
    res_t       res1;
  } dec_out_t;

  typedef struct packed {
    phase_e phase;
    logic   count_ok;
  } dec_stat_t;

endpackage

>>> rtl/pld_fifo.sv
// Result queue: takes zero, one or two words per cycle, hands out one.
// Depends on pld_pkg.
module pld_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [1:0]               push_n_i,
  input  pld_pkg::res_t            push0_i,
  input  pld_pkg::res_t            push1_i,
  input  logic                     pop_i,
  output pld_pkg::res_t            head_o,
  output logic [pld_pkg::FifoCntW-1:0] count_o
);
  import pld_pkg::*;

  res_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic [FifoPtrW-1:0] wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + FifoPtrW'(1);

  always_comb begin
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop_i);
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_n_i);
    count_d  = count_q + FifoCntW'(push_n_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

>>> rtl/pld_decode.sv
// Byte decoder: list state registers and the per-byte next-state logic.
// Depends on pld_pkg.
module pld_decode #(
  parameter int unsigned LENGTH_BITS = pld_pkg::LengthBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                message_start_i,
  input  logic [15:0]         message_length_i,
  input  pld_pkg::cfg_t       cfg_i,
  output pld_pkg::dec_out_t   out_o,
  output pld_pkg::dec_stat_t  stat_o
);
  import pld_pkg::*;

  localparam int unsigned SumW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

  phase_e                 phase_q, phase_d;
  logic [1:0]             hc_q, hc_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [LENGTH_BITS-1:0] tot_q, tot_d;
  logic [7:0]             slo_q, slo_d;
  logic [15:0]            id_q, id_d;
  logic [15:0]            len_q, len_d;
  logic [15:0]            vc_q, vc_d;

  phase_e                 ph;
  logic [1:0]             hc;
  logic [LENGTH_BITS-1:0] pos, tot, pos_inc;
  logic [15:0]            full_len;
  logic                   room, last, nh, prim_v, dend;
  res_t                   prim, dend_res;

  always_comb begin
    ph  = phase_q;
    hc  = hc_q;
    pos = pos_q;
    tot = tot_q;
    if (message_start_i) begin
      tot = LENGTH_BITS'(message_length_i);
      pos = '0;
      hc  = '0;
      ph  = PH_ENCAP;
    end
    phase_d  = ph;
    hc_d     = hc;
    pos_d    = pos;
    tot_d    = tot;
    slo_d    = slo_q;
    id_d     = id_q;
    len_d    = len_q;
    vc_d     = vc_q;
    prim_v   = 1'b0;
    prim     = '0;
    nh       = 1'b0;
    dend     = 1'b0;
    dend_res = '0;
    dend_res.kind = K_DEND;
    pos_inc  = pos + LENGTH_BITS'(1);
    full_len = {data_byte_i, len_q[7:0]};
    // header fits in what is left of the message
    room     = LENGTH_BITS'(tot - pos_inc) >= LENGTH_BITS'(HdrBytes);
    last     = ({1'b0, vc_q} + 17'd1) >= {1'b0, len_q};

    case (ph)
      PH_ENCAP: begin
        pos_d = pos_inc;
        if (tot < LENGTH_BITS'(HdrBytes)) begin
          phase_d   = PH_DONE;
          prim_v    = 1'b1;
          prim.kind = K_BADHDR;
        end else begin
          if (hc == 2'd0) begin
            slo_d = data_byte_i;
          end
          if (hc == 2'd1 && {data_byte_i, slo_q} != cfg_i.list_scheme) begin
            phase_d   = PH_DONE;
            prim_v    = 1'b1;
            prim.kind = K_BADHDR;
          end else begin
            hc_d = hc + 2'd1;
            nh   = (hc == 2'd3);
          end
        end
      end
      PH_HDR: begin
        pos_d = pos_inc;
        hc_d  = hc + 2'd1;
        case (hc)
          2'd0: id_d = {8'h00, data_byte_i};
          2'd1: id_d = {data_byte_i, id_q[7:0]};
          2'd2: len_d = {8'h00, data_byte_i};
          default: begin
            len_d = full_len;
            // sentinel wins over pad when both match
            if (id_q == cfg_i.sentinel_id) begin
              phase_d           = PH_DONE;
              prim_v            = 1'b1;
              prim.kind         = K_SENT;
              prim.param_id     = id_q;
              prim.param_length = full_len;
            end else if (SumW'(pos_inc) + SumW'(full_len) > SumW'(tot)) begin
              phase_d           = PH_DONE;
              prim_v            = 1'b1;
              prim.kind         = K_OVER;
              prim.param_id     = id_q;
              prim.param_length = full_len;
            end else if (full_len == 16'd0) begin
              if (id_q != cfg_i.pad_id) begin
                prim_v        = 1'b1;
                prim.kind     = K_EMPTY;
                prim.param_id = id_q;
              end
              nh = 1'b1;
            end else begin
              vc_d    = '0;
              phase_d = (id_q == cfg_i.pad_id) ? PH_SKIP : PH_VALUE;
            end
          end
        endcase
      end
      PH_VALUE, PH_SKIP: begin
        pos_d = pos_inc;
        if (ph == PH_VALUE) begin
          prim_v             = 1'b1;
          prim.kind          = K_VALUE;
          prim.param_id      = id_q;
          prim.param_length  = len_q;
          prim.byte_index    = vc_q;
          prim.value_byte    = data_byte_i;
          prim.last_in_param = last;
        end
        vc_d = vc_q + 16'd1;
        nh   = last;
      end
      default: ;
    endcase

    if (nh) begin
      hc_d = '0;
      if (!room) begin
        phase_d = PH_DONE;
        dend    = 1'b1;
      end else begin
        phase_d = PH_HDR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hc_q    <= '0;
      pos_q   <= '0;
      tot_q   <= '0;
      slo_q   <= '0;
      id_q    <= '0;
      len_q   <= '0;
      vc_q    <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      pos_q   <= pos_d;
      tot_q   <= tot_d;
      slo_q   <= slo_d;
      id_q    <= id_d;
      len_q   <= len_d;
      vc_q    <= vc_d;
    end
  end

  assign out_o.n    = 2'(prim_v) + 2'(dend);
  assign out_o.res0 = prim_v ? prim : dend_res;
  assign out_o.res1 = dend_res;

  assign stat_o.phase    = phase_q;
  assign stat_o.count_ok = (vc_q < len_q);

endmodule

>>> rtl/parameter_list_decoder_top.sv
// Parameter list decoder, top level: input register, config registers,
// decoder and result queue. Depends on pld_pkg, pld_decode, pld_fifo.
//
// Takes one message byte per cycle and sustains that rate as long as the result
// side keeps up. A byte is held in the input register, is decoded by a single
// pass of counter and compare logic, and its results (none, one or two words)
// land in a four-word queue whose head drives the outputs. A byte is decoded
// only when the queue has room for two words; with the result side stalled
// the input stalls once that room is gone. Configuration writes are taken
// every cycle and are meant to happen while no message is being decoded.
`include "parameter_list_decoder_top_defines.svh"

module parameter_list_decoder_top #(
  parameter int unsigned LENGTH_BITS = pld_pkg::LengthBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        message_start_i,
  input  logic [15:0]                 message_length_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  kind_o,
  output logic [15:0]                 param_id_o,
  output logic [15:0]                 param_length_o,
  output logic [15:0]                 byte_index_o,
  output logic [7:0]                  value_byte_o,
  output logic                        last_in_param_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pld_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i
);
  import pld_pkg::*;

  cfg_t                cfg_q;
  logic                in_valid_q;
  logic [7:0]          byte_q;
  logic                start_q;
  logic [15:0]         mlen_q;
  logic                fire, pop, in_acc;
  logic [FifoCntW-1:0] fifo_count;
  res_t                head;
  dec_out_t            dec;
  dec_stat_t           stat;
  logic                dec_end, in_value;

  // config word
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.list_scheme <= 16'd3;
      cfg_q.sentinel_id <= 16'd1;
      cfg_q.pad_id      <= 16'd0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LIST_SCHEME: cfg_q.list_scheme <= cfg_data_i;
        CFG_SENTINEL_ID: cfg_q.sentinel_id <= cfg_data_i;
        CFG_PAD_ID:      cfg_q.pad_id      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode when the queue can take two words after this cycle's pop
  assign pop  = out_valid_o && out_ready_i;
  assign fire = in_valid_q &&
                ((fifo_count <= FifoCntW'(FifoDepth - 2)) ||
                 (pop && fifo_count <= FifoCntW'(FifoDepth - 1)));
  assign in_ready_o = !in_valid_q || fire;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q  <= data_byte_i;
      start_q <= message_start_i;
      mlen_q  <= message_length_i;
    end
  end

  pld_decode #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .data_byte_i      (byte_q),
    .message_start_i  (start_q),
    .message_length_i (mlen_q),
    .cfg_i            (cfg_q),
    .out_o            (dec),
    .stat_o           (stat)
  );

  pld_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (fire ? dec.n : 2'd0),
    .push0_i  (dec.res0),
    .push1_i  (dec.res1),
    .pop_i    (pop),
    .head_o   (head),
    .count_o  (fifo_count)
  );

  assign out_valid_o     = (fifo_count != '0);
  assign kind_o          = head.kind;
  assign param_id_o      = head.param_id;
  assign param_length_o  = head.param_length;
  assign byte_index_o    = head.byte_index;
  assign value_byte_o    = head.value_byte;
  assign last_in_param_o = head.last_in_param;

  // any word that closes the list, or a data end behind another word
  assign dec_end  = fire && dec.n != 2'd0 &&
                    (dec.res0.kind == K_BADHDR || dec.res0.kind == K_SENT ||
                     dec.res0.kind == K_OVER || dec.res0.kind == K_DEND ||
                     dec.n == 2'd2);
  assign in_value = (stat.phase == PH_VALUE) || (stat.phase == PH_SKIP);

  `PLD_ASSERT(a_fifo_bound, fifo_count <= FifoCntW'(FifoDepth), "result queue overflow")
  `PLD_ASSERT_NEXT(a_end_done, dec_end, stat.phase == PH_DONE, "list end without done phase")
  `PLD_ASSERT_IMPL(a_value_count, in_value, stat.count_ok, "value count past length")

endmodule

>>> verif/tb_parameter_list_decoder_top.sv
// Testbench for parameter_list_decoder_top: directed and random parameter lists are
// streamed in one byte per word, each result word is checked against a local decoder.
// Depends on pld_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_parameter_list_decoder_top;
  import pld_pkg::*;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomBytes = 2000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned MaxBody     = 48;

  logic        clk_i;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        msg_start = 1'b0;
  logic [15:0] msg_len   = 16'h0000;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  cfg_idx_e    cfg_index = CFG_LIST_SCHEME;
  logic [15:0] cfg_data  = 16'h0000;

  logic        in_ready_o;
  logic        out_valid_o;
  logic        cfg_ready_o;
  logic [2:0]  kind_o;
  logic [15:0] param_id_o;
  logic [15:0] param_length_o;
  logic [15:0] byte_index_o;
  logic [7:0]  value_byte_o;
  logic        last_in_param_o;

  // register copies, reset values
  logic [15:0] want_scheme = 16'd3;
  logic [15:0] stop_id     = 16'd1;
  logic [15:0] filler_id   = 16'd0;

  // local decoder state
  phase_e            dec_phase = PH_IDLE;
  logic [1:0]        hdr_seen  = 2'd0;
  longint unsigned   msg_pos   = 0;
  longint unsigned   msg_total = 0;
  logic [7:0]        scheme_lo = 8'h00;
  logic [15:0]       par_id    = 16'h0000;
  logic [15:0]       par_len   = 16'h0000;
  logic [15:0]       val_idx   = 16'h0000;

  res_t        expected_words[$];
  logic [7:0]  msg_q[$];
  int unsigned taken_bytes    = 0;
  int unsigned errors         = 0;
  int unsigned stalled_cycles = 0;
  bit          steady         = 1'b0;

  parameter_list_decoder_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte),
    .message_start_i (msg_start),
    .message_length_i(msg_len),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .kind_o          (kind_o),
    .param_id_o      (param_id_o),
    .param_length_o  (param_length_o),
    .byte_index_o    (byte_index_o),
    .value_byte_o    (value_byte_o),
    .last_in_param_o (last_in_param_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void push_word(kind_e k, logic [15:0] id, logic [15:0] len,
                                    logic [15:0] idx, logic [7:0] vb, logic ends_here);
    res_t w;
    w.kind          = k;
    w.param_id      = id;
    w.param_length  = len;
    w.byte_index    = idx;
    w.value_byte    = vb;
    w.last_in_param = ends_here;
    expected_words = {expected_words, w};
  endfunction

  // another parameter header must fit, else the list ends with a data end
  function automatic void open_header();
    hdr_seen = 2'd0;
    if (msg_total - msg_pos < HdrBytes) begin
      dec_phase = PH_DONE;
      push_word(K_DEND, 16'h0, 16'h0, 16'h0, 8'h0, 1'b0);
    end else begin
      dec_phase = PH_HDR;
    end
  endfunction

  // returns 1 when the byte is part of an open list
  function automatic bit decode_byte(logic [7:0] b, logic st, logic [15:0] len);
    bit used;
    bit ends_here;
    if (st) begin
      msg_total = len;
      msg_pos   = 0;
      hdr_seen  = 2'd0;
      dec_phase = PH_ENCAP;
    end
    used = (dec_phase != PH_IDLE) && (dec_phase != PH_DONE);
    case (dec_phase)
      PH_ENCAP: begin
        msg_pos++;
        if (msg_total < HdrBytes) begin
          dec_phase = PH_DONE;
          push_word(K_BADHDR, 16'h0, 16'h0, 16'h0, 8'h0, 1'b0);
        end else if (hdr_seen == 2'd1 && {b, scheme_lo} != want_scheme) begin
          dec_phase = PH_DONE;
          push_word(K_BADHDR, 16'h0, 16'h0, 16'h0, 8'h0, 1'b0);
        end else begin
          if (hdr_seen == 2'd0) scheme_lo = b;
          hdr_seen = hdr_seen + 2'd1;
          if (hdr_seen == 2'd0) open_header();
        end
      end
      PH_HDR: begin
        msg_pos++;
        case (hdr_seen)
          2'd0: par_id = {8'h00, b};
          2'd1: par_id[15:8] = b;
          2'd2: par_len = {8'h00, b};
          default: par_len[15:8] = b;
        endcase
        hdr_seen = hdr_seen + 2'd1;
        if (hdr_seen == 2'd0) begin
          if (par_id == stop_id) begin
            dec_phase = PH_DONE;
            push_word(K_SENT, par_id, par_len, 16'h0, 8'h0, 1'b0);
          end else if (msg_pos + par_len > msg_total) begin
            dec_phase = PH_DONE;
            push_word(K_OVER, par_id, par_len, 16'h0, 8'h0, 1'b0);
          end else if (par_len == 16'h0) begin
            if (par_id != filler_id) push_word(K_EMPTY, par_id, 16'h0, 16'h0, 8'h0, 1'b0);
            open_header();
          end else begin
            val_idx   = 16'h0;
            dec_phase = (par_id == filler_id) ? PH_SKIP : PH_VALUE;
          end
        end
      end
      PH_VALUE, PH_SKIP: begin
        ends_here = (32'(val_idx) + 32'd1) >= 32'(par_len);
        msg_pos++;
        if (dec_phase == PH_VALUE) push_word(K_VALUE, par_id, par_len, val_idx, b, ends_here);
        val_idx = val_idx + 16'd1;
        if (ends_here) open_header();
      end
      default: ;
    endcase
    return used;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void flag_word(string why, res_t want, res_t got);
    errors++;
    if (errors <= ReportLimit)
      $display({"%s: exp kind=%0d id=%h len=%h idx=%h byte=%h last=%b",
                " | got kind=%0d id=%h len=%h idx=%h byte=%h last=%b"},
               why, want.kind, want.param_id, want.param_length, want.byte_index,
               want.value_byte, want.last_in_param, got.kind, got.param_id,
               got.param_length, got.byte_index, got.value_byte, got.last_in_param);
  endfunction

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid_o && out_ready) begin
      got.kind          = kind_e'(kind_o);
      got.param_id      = param_id_o;
      got.param_length  = param_length_o;
      got.byte_index    = byte_index_o;
      got.value_byte    = value_byte_o;
      got.last_in_param = last_in_param_o;
      if (expected_words.size() == 0) begin
        want = '0;
        flag_word("unexpected word", want, got);
      end else begin
        want = expected_words.pop_front();
        if (got.kind !== want.kind || got.param_id !== want.param_id ||
            got.param_length !== want.param_length || got.byte_index !== want.byte_index ||
            got.value_byte !== want.value_byte || got.last_in_param !== want.last_in_param)
          flag_word("mismatch", want, got);
      end
    end
    out_ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_byte(logic [7:0] b, logic st, logic [15:0] len);
    if (!steady)
      while ($urandom_range(0, 99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    in_valid  <= 1'b1;
    data_byte <= b;
    msg_start <= st;
    msg_len   <= len;
    do @(posedge clk_i); while (!in_ready_o);
    if (decode_byte(b, st, len)) taken_bytes++;
  endtask

  // length is only sampled on the first byte, the others carry junk
  task automatic send_message(logic [15:0] declared);
    foreach (msg_q[i])
      send_byte(msg_q[i], i == 0, (i == 0) ? declared : 16'($urandom));
    msg_q.delete();
  endtask

  task automatic send_noise(int unsigned count);
    repeat (count) send_byte(8'($urandom), 1'b0, 16'($urandom));
  endtask

  // sender holds off until every result is back; bytes with no result need the extra cycles
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_registers(logic [15:0] scheme, logic [15:0] stop, logic [15:0] filler);
    cfg_idx_e    regs[3] = '{CFG_LIST_SCHEME, CFG_SENTINEL_ID, CFG_PAD_ID};
    logic [15:0] vals[3];
    vals = '{scheme, stop, filler};
    drain_results();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid   <= 1'b0;
    want_scheme = scheme;
    stop_id     = stop;
    filler_id   = filler;
  endtask

  function automatic void add_byte(logic [7:0] v);
    msg_q = {msg_q, v};
  endfunction

  function automatic void add_word(logic [15:0] v);
    add_byte(v[7:0]);
    add_byte(v[15:8]);
  endfunction

  function automatic void start_list(logic [15:0] scheme);
    msg_q.delete();
    add_word(scheme);
    add_word(16'($urandom));
  endfunction

  // body is capped: huge lengths only matter for the overrun check
  function automatic void put_param(logic [15:0] id, logic [15:0] len);
    add_word(id);
    add_word(len);
    repeat ((len > MaxBody) ? MaxBody : len) add_byte(8'($urandom));
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_stray_bytes();
    send_noise(3);
  endtask

  task automatic test_header_faults();
    start_list(16'd3);
    send_message(16'd0);
    start_list(16'd3);
    send_message(16'd3);
    start_list(16'h0103);
    put_param(16'h0002, 16'd1);
    send_message(16'd9);
    start_list(16'h0002);
    send_message(16'd4);
    start_list(16'd3);
    send_message(16'd4);
    start_list(16'd3);
    send_message(16'd7);
  endtask

  task automatic test_param_kinds();
    int unsigned declared;
    start_list(16'd3);
    add_word(16'hFFFF);
    add_word(16'd3);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h5A);
    put_param(16'h1234, 16'd0);
    put_param(16'h0000, 16'd2);
    put_param(16'h0000, 16'd0);
    put_param(16'h0001, 16'd2);
    declared = msg_q.size();
    add_byte(8'hC3);
    add_byte(8'h3C);
    send_message(16'(declared));
    // last value byte and data end on the same byte
    start_list(16'd3);
    put_param(16'h0005, 16'd2);
    send_message(16'(msg_q.size() + 3));
    start_list(16'd3);
    put_param(16'h0006, 16'd0);
    send_message(16'(msg_q.size() + 2));
    start_list(16'd3);
    put_param(16'h0000, 16'd1);
    send_message(16'(msg_q.size() + 1));
    start_list(16'd3);
    add_word(16'h0007);
    add_word(16'hFFFF);
    send_message(16'd12);
    start_list(16'd3);
    add_word(16'h0000);
    add_word(16'd10);
    add_byte(8'h11);
    add_byte(8'h22);
    send_message(16'd12);
    // lists cut short by a new start, in the value and in the header
    start_list(16'd3);
    add_word(16'h0009);
    add_word(16'd8);
    repeat (3) add_byte(8'($urandom));
    send_message(16'hFFFF);
    start_list(16'd3);
    void'(msg_q.pop_back());
    void'(msg_q.pop_back());
    send_message(16'd20);
    start_list(16'd3);
    put_param(16'h0001, 16'd0);
    send_message(16'(msg_q.size()));
  endtask

  task automatic test_register_extremes();
    load_registers(16'hFFFF, 16'h0000, 16'hFFFF);
    start_list(16'hFFFF);
    put_param(16'hFFFF, 16'd1);
    put_param(16'h0001, 16'd1);
    put_param(16'h0000, 16'd0);
    send_message(16'(msg_q.size()));
    // sentinel and pad share an id: the list ends
    load_registers(16'h0000, 16'h00AA, 16'h00AA);
    start_list(16'h0000);
    put_param(16'h0005, 16'd0);
    put_param(16'h00AA, 16'd2);
    send_message(16'(msg_q.size()));
    load_registers(16'h8001, 16'hFFFF, 16'h0000);
    start_list(16'h8001);
    put_param(16'h0000, 16'd0);
    put_param(16'h0001, 16'd1);
    put_param(16'hFFFF, 16'd0);
    send_message(16'(msg_q.size()));
  endtask

  task automatic send_random_message();
    int unsigned size;
    int unsigned declared;
    int unsigned keep;
    logic [15:0] scheme;
    logic [15:0] id;
    logic [15:0] len;
    int unsigned r;
    scheme = want_scheme;
    if ($urandom_range(0, 19) == 0) scheme = scheme ^ (16'h1 << $urandom_range(0, 15));
    start_list(scheme);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0, 1: id = filler_id;
        2: id = 16'($urandom);
        default: id = 16'($urandom_range(0, 15));
      endcase
      r = $urandom_range(0, 19);
      if (r < 6) len = 16'd0;
      else if (r < 18) len = 16'($urandom_range(1, 6));
      else if (r == 18) len = 16'($urandom_range(7, 40));
      else len = 16'($urandom);
      put_param(id, len);
    end
    if ($urandom_range(0, 4) != 0) put_param(stop_id, 16'($urandom_range(0, 3)));
    size = msg_q.size();
    case ($urandom_range(0, 9))
      6: declared = (size > 6) ? size - $urandom_range(1, 6) : size;
      7: declared = size + $urandom_range(1, 10);
      8: declared = $urandom_range(0, 3);
      9: declared = $urandom_range(0, 65535);
      default: declared = size;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, size);
      while (msg_q.size() > keep) void'(msg_q.pop_back());
    end
    send_message(16'(declared));
    if ($urandom_range(0, 7) == 0) send_noise($urandom_range(1, 4));
  endtask

  task automatic test_random_lists();
    int unsigned base;
    int unsigned round;
    logic [15:0] stop;
    logic [15:0] filler;
    base  = taken_bytes;
    round = 0;
    while (taken_bytes - base < RandomBytes) begin
      stop   = pick_word();
      filler = ($urandom_range(0, 3) == 0) ? stop : pick_word();
      load_registers(pick_word(), stop, filler);
      steady = (round == 1);
      repeat (20) send_random_message();
      round++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    test_stray_bytes();
    test_header_faults();
    test_param_kinds();
    test_register_extremes();
    test_random_lists();
    drain_results();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
